FILE: rtl/bpg_pkg.sv
package bpg_pkg;

	// Item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_MOVE  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_NOP   = 2'd3;

	// Configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam int CoordW = 6;
	localparam int DimW   = 7;
	localparam int LimW   = 2 * DimW;

	localparam logic [DimW-1:0] WIDTH_RST  = 7'd7;
	localparam logic [DimW-1:0] HEIGHT_RST = 7'd6;

	// King-move offsets per direction
	localparam logic signed [1:0] STEP_DX [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
		2'sd1, -2'sd1, 2'sd0, 2'sd1};
	localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
		2'sd0, 2'sd1, 2'sd1, 2'sd1};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_RD_IDX,
		OP_CAP_READ,
		OP_RD_END,
		OP_CAP_END,
		OP_SRD,
		OP_SCMP,
		OP_NOHIT,
		OP_FRD_LO,
		OP_FRD_HI,
		OP_FWR_LO,
		OP_FWR_HI,
		OP_APPEND,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       move_ok;
		logic       nb_ok;
		logic       cnt_zero;
		logic       cnt_one;
		logic       hit;
		logic       lo_lt_hi;
		logic       out_free;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_WAIT,
		S_END_WAIT,
		S_NB_CHK,
		S_SRD,
		S_SCMP,
		S_NOHIT,
		S_FCHK,
		S_FRD_LO,
		S_FRD_HI,
		S_FWR_LO,
		S_FWR_HI,
		S_APPEND,
		S_EMIT
	} ctrl_state_t;

endpackage

FILE: rtl/backbite_path_generator.sv
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  kind side direction start_x start_y index
// output    out        out_valid / out_stall path_length cell_x cell_y grew complete
// config    in         cfg_we               cfg_index cfg_data
//
// One item at a time. A move reads the end cell, scans the path cells for its neighbour,
// reverses a segment by swapping pairs and, on no hit, appends the neighbour.
// Reset clears the length and sets the sizes to 7 by 6; the path memory is not cleared.
// A held result does not block a new item; the item waits at its end for the output.
module backbite_path_generator #(
	parameter int MAX_CELLS = 1024,
	parameter int MAX_SIDE  = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [bpg_pkg::DimW-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic                     side,
	input  logic [2:0]               direction,
	input  logic [5:0]               start_x,
	input  logic [5:0]               start_y,
	input  logic [9:0]               index,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [10:0]              path_length,
	output logic [5:0]               cell_x,
	output logic [5:0]               cell_y,
	output logic                     grew,
	output logic                     complete
);
	import bpg_pkg::*;

	dp_op_t     op;
	dp_status_t st;

	// Sequencer
	bpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.op       (op)
	);

	// Path store and arithmetic
	bpg_datapath #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_SIDE  (MAX_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.side        (side),
		.direction   (direction),
		.start_x     (start_x),
		.start_y     (start_y),
		.index       (index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_length (path_length),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.grew        (grew),
		.complete    (complete)
	);

endmodule

FILE: rtl/bpg_ctrl.sv
module bpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bpg_pkg::dp_status_t st,
	output bpg_pkg::dp_op_t     op
);
	import bpg_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        app_q, app_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			app_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			app_q   <= app_d;
		end
	end

	// Next state and datapath command
	always_comb begin
		state_d  = state_q;
		app_d    = app_q;
		op       = OP_NONE;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				app_d    = 1'b0;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (st.kind)
					KIND_START: begin
						op      = OP_START;
						state_d = S_EMIT;
					end
					KIND_READ: begin
						op      = OP_RD_IDX;
						state_d = S_RD_WAIT;
					end
					KIND_MOVE: begin
						if (st.move_ok) begin
							op      = OP_RD_END;
							state_d = S_END_WAIT;
						end else begin
							state_d = S_EMIT;
						end
					end
					default: state_d = S_EMIT;
				endcase
			end
			S_RD_WAIT: begin
				op      = OP_CAP_READ;
				state_d = S_EMIT;
			end
			S_END_WAIT: begin
				op      = OP_CAP_END;
				state_d = S_NB_CHK;
			end
			S_NB_CHK: begin
				if (!st.nb_ok) state_d = S_EMIT;
				else if (st.cnt_zero) state_d = S_NOHIT;
				else state_d = S_SRD;
			end
			S_SRD: begin
				op      = OP_SRD;
				state_d = S_SCMP;
			end
			S_SCMP: begin
				op = OP_SCMP;
				if (st.hit) state_d = S_FCHK;
				else if (st.cnt_one) state_d = S_NOHIT;
				else state_d = S_SRD;
			end
			S_NOHIT: begin
				op      = OP_NOHIT;
				app_d   = 1'b1;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				if (st.lo_lt_hi) state_d = S_FRD_LO;
				else if (app_q) state_d = S_APPEND;
				else state_d = S_EMIT;
			end
			S_FRD_LO: begin
				op      = OP_FRD_LO;
				state_d = S_FRD_HI;
			end
			S_FRD_HI: begin
				op      = OP_FRD_HI;
				state_d = S_FWR_LO;
			end
			S_FWR_LO: begin
				op      = OP_FWR_LO;
				state_d = S_FWR_HI;
			end
			S_FWR_HI: begin
				op      = OP_FWR_HI;
				state_d = S_FCHK;
			end
			S_APPEND: begin
				op      = OP_APPEND;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					op      = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: rtl/bpg_datapath.sv
module bpg_datapath #(
	parameter int MAX_CELLS = 1024,
	parameter int MAX_SIDE  = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpg_pkg::dp_op_t           op,
	output bpg_pkg::dp_status_t       st,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bpg_pkg::DimW-1:0]  cfg_data,
	input  logic [1:0]                kind,
	input  logic                      side,
	input  logic [2:0]                direction,
	input  logic [5:0]                start_x,
	input  logic [5:0]                start_y,
	input  logic [9:0]                index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [10:0]               path_length,
	output logic [5:0]                cell_x,
	output logic [5:0]                cell_y,
	output logic                      grew,
	output logic                      complete
);
	import bpg_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int LW = $clog2(MAX_CELLS + 1);
	localparam int CW = 2 * CoordW;

	// Path store, {row, col}
	logic [CW-1:0] mem [MAX_CELLS];
	logic [CW-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          rd_en;
	logic          we;
	logic [AW-1:0] waddr;
	logic [CW-1:0] wdata;

	logic [DimW-1:0]   width_q, height_q;
	logic [LW-1:0]     length_q;
	logic [1:0]        kind_q;
	logic              side_q;
	logic [2:0]        dir_q;
	logic [5:0]        sx_q, sy_q;
	logic [9:0]        idx_q;
	logic [CoordW-1:0] nx_q, ny_q;
	logic              nb_ok_q;
	logic [LW-1:0]     cnt_q;
	logic [AW-1:0]     ptr_q, lo_q, hi_q;
	logic [CW-1:0]     tmp_q;
	logic [CoordW-1:0] cx_q, cy_q;
	logic              grew_q;
	logic              ov_q;
	logic [10:0]       o_len_q;
	logic [5:0]        o_cx_q, o_cy_q;
	logic              o_grew_q, o_cmp_q;

	// Effective grid and cell limit
	logic [DimW-1:0] eff_w, eff_h;
	logic [LimW-1:0] lim;
	logic [LimW-1:0] prod;
	logic [LimW-1:0] len_ext;
	assign eff_w   = (width_q > DimW'(MAX_SIDE)) ? DimW'(MAX_SIDE) : width_q;
	assign eff_h   = (height_q > DimW'(MAX_SIDE)) ? DimW'(MAX_SIDE) : height_q;
	assign prod    = LimW'(eff_w) * LimW'(eff_h);
	assign lim     = (prod > LimW'(MAX_CELLS)) ? LimW'(MAX_CELLS) : prod;
	assign len_ext = LimW'(length_q);

	// Neighbor of the end cell
	logic signed [DimW:0] nbx, nby;
	assign nbx = $signed({2'b00, rdata_q[CoordW-1:0]}) + (DimW+1)'(STEP_DX[dir_q]);
	assign nby = $signed({2'b00, rdata_q[CW-1:CoordW]}) + (DimW+1)'(STEP_DY[dir_q]);

	logic start_ok, read_ok;
	assign start_ok = ({1'b0, sx_q} < eff_w) && ({1'b0, sy_q} < eff_h);
	assign read_ok  = LW'(idx_q) < length_q && (32'(idx_q) < 32'(length_q));

	logic [AW-1:0] len_a;
	assign len_a = length_q[AW-1:0];

	// Status
	assign st.kind     = kind_q;
	assign st.move_ok  = (length_q != '0) && (len_ext < lim);
	assign st.nb_ok    = nb_ok_q;
	assign st.cnt_zero = (cnt_q == '0);
	assign st.cnt_one  = (cnt_q == LW'(1));
	assign st.hit      = (rdata_q == {ny_q, nx_q});
	assign st.lo_lt_hi = (lo_q < hi_q);
	assign st.out_free = !ov_q || !out_stall;

	// Memory address and write selection
	always_comb begin
		raddr = '0;
		rd_en = 1'b0;
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		case (op)
			OP_RD_IDX: begin
				rd_en = 1'b1;
				raddr = AW'(idx_q);
			end
			OP_RD_END: begin
				rd_en = 1'b1;
				raddr = side_q ? '0 : len_a - AW'(1);
			end
			OP_SRD: begin
				rd_en = 1'b1;
				raddr = ptr_q;
			end
			OP_FRD_LO: begin
				rd_en = 1'b1;
				raddr = lo_q;
			end
			OP_FRD_HI: begin
				rd_en = 1'b1;
				raddr = hi_q;
			end
			OP_START: begin
				we    = start_ok;
				wdata = {sy_q, sx_q};
			end
			OP_FWR_LO: begin
				we    = 1'b1;
				waddr = lo_q;
			end
			OP_FWR_HI: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = tmp_q;
			end
			OP_APPEND: begin
				we    = 1'b1;
				waddr = len_a;
				wdata = {ny_q, nx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	// Control registers: config, length, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			length_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (op == OP_START && start_ok) length_q <= LW'(1);
			if (op == OP_APPEND) length_q <= length_q + LW'(1);
			if (op == OP_EMIT) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	// Item working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				kind_q <= kind;
				side_q <= side;
				dir_q  <= direction;
				sx_q   <= start_x;
				sy_q   <= start_y;
				idx_q  <= index;
				cx_q   <= '0;
				cy_q   <= '0;
				grew_q <= 1'b0;
			end
			OP_CAP_READ: begin
				if (read_ok) begin
					cx_q <= rdata_q[CoordW-1:0];
					cy_q <= rdata_q[CW-1:CoordW];
				end
			end
			OP_CAP_END: begin
				nx_q    <= nbx[CoordW-1:0];
				ny_q    <= nby[CoordW-1:0];
				nb_ok_q <= !nbx[DimW] && !nby[DimW] &&
					(nbx[DimW-1:0] < eff_w) && (nby[DimW-1:0] < eff_h);
				cnt_q   <= length_q - LW'(1);
				ptr_q   <= side_q ? AW'(1) : len_a - AW'(2);
				lo_q    <= '0;
				hi_q    <= '0;
			end
			OP_SCMP: begin
				if (st.hit) begin
					if (side_q) begin
						lo_q <= '0;
						hi_q <= ptr_q - AW'(1);
					end else begin
						lo_q <= ptr_q + AW'(1);
						hi_q <= len_a - AW'(1);
					end
				end else begin
					cnt_q <= cnt_q - LW'(1);
					ptr_q <= side_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
				end
			end
			OP_NOHIT: begin
				lo_q <= '0;
				hi_q <= side_q ? len_a - AW'(1) : '0;
			end
			OP_FRD_HI: tmp_q <= rdata_q;
			OP_FWR_HI: begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			OP_APPEND: grew_q <= 1'b1;
			default: ;
		endcase
	end

	// Result word
	always_ff @(posedge clk) begin
		if (op == OP_EMIT) begin
			o_len_q  <= 11'(length_q);
			o_cx_q   <= cx_q;
			o_cy_q   <= cy_q;
			o_grew_q <= grew_q;
			o_cmp_q  <= (len_ext == lim);
		end
	end

	assign out_valid   = ov_q;
	assign path_length = o_len_q;
	assign cell_x      = o_cx_q;
	assign cell_y      = o_cy_q;
	assign grew        = o_grew_q;
	assign complete    = o_cmp_q;

endmodule
